// ===== sv/grs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and controller/datapath interface types for the group rank scorer
// no dependencies

package grs_pkg;

    localparam int MAX_GROUP_DEF  = 32;
    localparam int VALUE_W        = 32;
    localparam int SIZE_W         = 6;
    localparam int SCORE_W        = 6;
    localparam int POS_W          = 5;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [SIZE_W-1:0] GROUP_SIZE_RST = SIZE_W'(20);

    // commands from the controller to the datapath
    typedef struct packed {
        logic store;
        logic cfg_wr;
        logic fetch;
        logic capture;
        logic scan;
        logic emit;
    } grs_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic j_done;
        logic i_last;
        logic out_free;
    } grs_sts_t;

endpackage

// ===== sv/grs_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module grs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/grs_datapath.sv =====
`timescale 1ns / 1ps
// datapath: group size register, value store, counters, rank accumulator, output register
// depends on grs_pkg and grs_ram

module grs_datapath
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  grs_cmd_t               cmd,
    output grs_sts_t               sts,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  logic [VALUE_W-1:0]     value,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [SCORE_W-1:0]     score,
    output logic [POS_W-1:0]       position,
    output logic                   group_end
);

    localparam int IDX_W = $clog2(MAX_GROUP);
    localparam int CNT_W = $clog2(MAX_GROUP + 1);

    logic [SIZE_W-1:0]  gs_reg;
    logic [CNT_W-1:0]   load_cnt_reg;
    logic [CNT_W-1:0]   load_inc;
    logic [IDX_W-1:0]   i_cnt_reg;
    logic [CNT_W-1:0]   j_cnt_reg;
    logic [CNT_W-1:0]   rank_reg;
    logic [VALUE_W-1:0] vi_reg;
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   diff;
    logic [IDX_W-1:0]   raddr;
    logic [VALUE_W-1:0] rdata;
    logic               outv_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               last_reg;

    // zero acts as one, anything above the store depth is clamped
    always_comb
    begin
        if (gs_reg == '0)
        begin
            n = CNT_W'(1);
        end
        else if (32'(gs_reg) > MAX_GROUP)
        begin
            n = CNT_W'(MAX_GROUP);
        end
        else
        begin
            n = CNT_W'(gs_reg);
        end
    end

    assign load_inc = load_cnt_reg + CNT_W'(1);
    assign diff     = n - rank_reg;

    always_comb
    begin
        if (cmd.fetch)
        begin
            raddr = i_cnt_reg;
        end
        else if (cmd.capture)
        begin
            raddr = '0;
        end
        else
        begin
            raddr = j_cnt_reg[IDX_W-1:0];
        end
    end

    grs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_GROUP)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (load_cnt_reg[IDX_W-1:0]),
        .wdata (value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg       <= GROUP_SIZE_RST;
            load_cnt_reg <= '0;
            i_cnt_reg    <= '0;
            j_cnt_reg    <= '0;
            rank_reg     <= '0;
            outv_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                gs_reg       <= cfg_data;
                load_cnt_reg <= '0;
            end
            else if (cmd.store)
            begin
                if (sts.full)
                begin
                    load_cnt_reg <= '0;
                    i_cnt_reg    <= '0;
                end
                else
                begin
                    load_cnt_reg <= load_inc;
                end
            end

            if (cmd.capture)
            begin
                j_cnt_reg <= CNT_W'(1);
                rank_reg  <= '0;
            end
            else if (cmd.scan)
            begin
                // rdata holds the entry addressed in the previous cycle
                j_cnt_reg <= j_cnt_reg + CNT_W'(1);
                if ($signed(rdata) < $signed(vi_reg))
                begin
                    rank_reg <= rank_reg + CNT_W'(1);
                end
            end

            if (cmd.emit)
            begin
                outv_reg  <= 1'b1;
                i_cnt_reg <= i_cnt_reg + IDX_W'(1);
            end
            else if (outv_reg && out_ready)
            begin
                outv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vi_reg <= rdata;
        end
        if (cmd.emit)
        begin
            score_reg <= SCORE_W'(diff);
            pos_reg   <= POS_W'(i_cnt_reg);
            last_reg  <= sts.i_last;
        end
    end

    assign sts.full     = (load_inc == n);
    assign sts.j_done   = (j_cnt_reg == n);
    assign sts.i_last   = (CNT_W'(i_cnt_reg) == (n - CNT_W'(1)));
    assign sts.out_free = !outv_reg || out_ready;

    assign out_valid = outv_reg;
    assign score     = score_reg;
    assign position  = pos_reg;
    assign group_end = last_reg;

endmodule

// ===== sv/grs_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences loading, per-value rank scan and result hand-off
// depends on grs_pkg

module grs_ctrl
    import grs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  grs_sts_t sts,
    output grs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CAPT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        cfg_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready   = 1'b1;
                // a register write takes precedence over a value request
                in_ready    = !cfg_valid;
                cmd.cfg_wr  = cfg_valid;
                cmd.store   = in_valid && !cfg_valid;
                if (cmd.store && sts.full)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.j_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.i_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/group_rank_scorer_core.sv =====
`timescale 1ns / 1ps
// group rank scorer: buffers a group of signed values, emits modified competition-rank scores
// depends on grs_pkg, grs_ctrl, grs_datapath, grs_ram
// throughput: one value request per cycle while loading, unless a register write is pending;
//   no value is taken again until the group's last result is emitted; each result passes
//   through fetch, capture, n compare reads on the single store read port, emit (n = group size)
// reset: group_size returns to 20 and the load count to zero; store contents stay undefined

module group_rank_scorer_core
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SIZE_W-1:0]      cfg_data,       // group_size
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] score, [10:6] position, rest zero
    output logic                   m_axis_tlast
);

    grs_cmd_t           cmd;
    grs_sts_t           sts;
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   position;

    grs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    grs_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_data  (cfg_data),
        .value     (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .score     (score),
        .position  (position),
        .group_end (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - SCORE_W - POS_W){1'b0}}, position, score};

endmodule
